/* hw/rtl/indexed_deque_defines.svh */
// assertion macros used by the checker file
`ifndef INDEXED_DEQUE_DEFINES_SVH
`define INDEXED_DEQUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define IDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define IDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/idq_pkg.sv */
// shared types and constants of the indexed deque
package idq_pkg;

  localparam int KIND_W  = 4;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_BACK  = 4'd0,
    K_PUSH_FRONT = 4'd1,
    K_INSERT_AT  = 4'd2,
    K_POP_FRONT  = 4'd3,
    K_POP_BACK   = 4'd4,
    K_REMOVE_AT  = 4'd5,
    K_READ_AT    = 4'd6,
    K_READ_FIRST = 4'd7,
    K_READ_LAST  = 4'd8,
    K_CLEAR      = 4'd9
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

/* hw/rtl/idq_if.sv */
// request and response channel interfaces
interface idq_req_if;
  import idq_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [POS_W-1:0]   position;
  logic [VALUE_W-1:0] value;
  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface idq_rsp_if;
  import idq_pkg::*;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic [ERR_W-1:0]   error;
  logic [COUNT_W-1:0] count;
  modport source (output valid, data_out, error, count, input ready);
  modport sink (input valid, data_out, error, count, output ready);
endinterface

/* hw/rtl/idq_ctrl.sv */
// handshake controller: tracks whether a result word is held
module idq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output idq_pkg::cmd_t cmd
);
  import idq_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HOLD  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign rsp_valid = (state == ST_HOLD);
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign cmd.exec  = accept;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (rsp_ready && !accept) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/idq_dp.sv */
// datapath: row of shifting cells, fill count and result register
module idq_dp #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  idq_pkg::cmd_t                cmd,
  input  logic [idq_pkg::KIND_W-1:0]   kind,
  input  logic [idq_pkg::POS_W-1:0]    position,
  input  logic [idq_pkg::VALUE_W-1:0]  value,
  output logic [idq_pkg::DATA_W-1:0]   data_out,
  output logic [idq_pkg::ERR_W-1:0]    error,
  output logic [idq_pkg::COUNT_W-1:0]  count
);
  import idq_pkg::*;

  localparam int IW  = $clog2(DEPTH);
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int CW0 = (FW > POS_W) ? FW : POS_W;
  localparam int CW  = (CW0 > COUNT_W) ? CW0 : COUNT_W;
  localparam int VW  = (WORD_BITS > VALUE_W) ? WORD_BITS : VALUE_W;
  localparam int DW  = (WORD_BITS > DATA_W) ? WORD_BITS : DATA_W;

  logic [WORD_BITS-1:0] cells [DEPTH];
  logic [WORD_BITS-1:0] cell_next [DEPTH];
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;

  logic [CW-1:0]        fill_c;
  logic [CW-1:0]        pos_c;
  logic [CW-1:0]        at;
  logic                 do_ins;
  logic                 do_rem;
  logic                 do_take;
  err_t                 err;
  logic [VW-1:0]        val_ext;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] rd_word;
  logic [DW-1:0]        rd_ext;
  logic [DATA_W-1:0]    data_next;
  logic [CW-1:0]        count_c;

  assign fill_c   = CW'(fill);
  assign pos_c    = CW'(position);
  assign val_ext  = VW'(value);
  assign new_word = val_ext[WORD_BITS-1:0];
  assign rd_word  = cells[at[IW-1:0]];
  assign rd_ext   = DW'(rd_word);

  always_comb begin
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    do_take   = 1'b0;
    at        = '0;
    err       = ERR_OK;
    fill_next = fill;
    unique case (kind)
      K_PUSH_BACK: begin
        if (fill_c >= CW'(DEPTH)) err = ERR_FULL;
        else begin
          do_ins = 1'b1;
          at     = fill_c;
        end
      end
      K_PUSH_FRONT: begin
        if (fill_c >= CW'(DEPTH)) err = ERR_FULL;
        else do_ins = 1'b1;
      end
      K_INSERT_AT: begin
        if (pos_c > fill_c) err = ERR_RANGE;
        else if (fill_c >= CW'(DEPTH)) err = ERR_FULL;
        else begin
          do_ins = 1'b1;
          at     = pos_c;
        end
      end
      K_POP_FRONT: begin
        if (fill_c == '0) err = ERR_RANGE;
        else begin
          do_rem  = 1'b1;
          do_take = 1'b1;
        end
      end
      K_POP_BACK: begin
        if (fill_c == '0) err = ERR_RANGE;
        else begin
          do_rem  = 1'b1;
          do_take = 1'b1;
          at      = fill_c - CW'(1);
        end
      end
      K_REMOVE_AT: begin
        if (pos_c >= fill_c) err = ERR_RANGE;
        else begin
          do_rem  = 1'b1;
          do_take = 1'b1;
          at      = pos_c;
        end
      end
      K_READ_AT: begin
        if (pos_c >= fill_c) err = ERR_RANGE;
        else begin
          do_take = 1'b1;
          at      = pos_c;
        end
      end
      K_READ_FIRST: begin
        if (fill_c == '0) err = ERR_RANGE;
        else do_take = 1'b1;
      end
      K_READ_LAST: begin
        if (fill_c == '0) err = ERR_RANGE;
        else begin
          do_take = 1'b1;
          at      = fill_c - CW'(1);
        end
      end
      K_CLEAR: begin
        fill_next = '0;
      end
      default: ;
    endcase
    if (do_ins) fill_next = fill + FW'(1);
    if (do_rem) fill_next = fill - FW'(1);
  end

  assign data_next = do_take ? rd_ext[DATA_W-1:0] : '0;
  assign count_c   = CW'(fill_next);

  // each cell takes its neighbor on a shift, the new word at the gap
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] below;
    logic [WORD_BITS-1:0] above;
    if (g == 0) begin : g_first
      assign below = cells[g];
    end else begin : g_mid
      assign below = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign above = cells[g];
    end else begin : g_inner
      assign above = cells[g+1];
    end
    always_comb begin
      cell_next[g] = cells[g];
      if (do_ins) begin
        if (CW'(g) > at) cell_next[g] = below;
        else if (CW'(g) == at) cell_next[g] = new_word;
      end else if (do_rem) begin
        if (CW'(g) >= at) cell_next[g] = above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells    <= cell_next;
      data_out <= data_next;
      error    <= err;
      count    <= count_c[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

endmodule

/* hw/rtl/indexed_deque.sv */
// indexed deque top level: request in, one response word out per request
// A bounded ordered list of up to DEPTH words with push/pop at both ends,
// insert/remove at an index (later entries shift by one place), reads and
// clear. Every request word gives exactly one response word: the data read
// or removed, an error code (range/empty or full, state unchanged on error)
// and the element count afterwards. A request is executed in the cycle it is
// accepted, and its response is registered and shown from the next cycle;
// a new request is taken every cycle while the response side keeps up; the
// row of cells shifts all entries at once.
module indexed_deque #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  idq_req_if.sink  req,
  idq_rsp_if.source rsp
);
  import idq_pkg::*;

  cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  idq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .kind     (req.kind),
    .position (req.position),
    .value    (req.value),
    .data_out (rsp.data_out),
    .error    (rsp.error),
    .count    (rsp.count)
  );

endmodule

/* hw/rtl/idq_checker.sv */
// port-level checker for the indexed deque and its bind
`include "indexed_deque_defines.svh"

module idq_checker #(
  parameter int DEPTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [idq_pkg::KIND_W-1:0]   req_kind,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [idq_pkg::DATA_W-1:0]   rsp_data_out,
  input logic [idq_pkg::ERR_W-1:0]    rsp_error,
  input logic [idq_pkg::COUNT_W-1:0]  rsp_count
);
  import idq_pkg::*;

  logic accept;
  assign accept = req_valid && req_ready;

  `IDQ_ASSERT_NEXT(a_word_follows, accept, rsp_valid,
    "accepted word gave no response")

  `IDQ_ASSERT_NOW(a_no_spurious, $rose(rsp_valid), $past(accept),
    "response without request")

  `IDQ_ASSERT_NEXT(a_clear, accept && (req_kind == K_CLEAR),
    (rsp_count == '0) && (rsp_error == ERR_OK),
    "clear did not empty the list")

  `IDQ_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp_data_out) && $stable(rsp_error) && $stable(rsp_count),
    "stalled response changed")

  `IDQ_ASSERT_NOW(a_count_range, rsp_valid, int'(rsp_count) <= DEPTH,
    "count above depth")

endmodule

bind indexed_deque idq_checker #(
  .DEPTH (DEPTH)
) u_idq_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_kind     (req.kind),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_data_out (rsp.data_out),
  .rsp_error    (rsp.error),
  .rsp_count    (rsp.count)
);

/* test/testbench.sv */
// self-checking testbench for the indexed deque: directed and random operations against a predictor
`timescale 1ns / 1ps

module testbench;
  import idq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int RAND_WORDS = 1550;
  localparam int CALM_TAIL  = 150;
  localparam int HOLD_AT    = 400;
  localparam int HOLD_LEN   = 60;

  typedef struct {
    logic [DATA_W-1:0]  data;
    err_t               err;
    logic [COUNT_W-1:0] count;
  } rsp_word_t;

  class deque_scoreboard;
    logic [WORD_BITS-1:0] entries [DEPTH];
    int                   fill;
    rsp_word_t            pending [$];
    int                   failures;
    int                   words_in;
    int                   words_out;
    int                   kind_seen [10];
    int                   err_seen [3];
    int                   peak_fill;

    function new();
      fill = 0;
      failures = 0;
      words_in = 0;
      words_out = 0;
      peak_fill = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (err_seen[i]) err_seen[i] = 0;
    endfunction

    function void open_gap(int at, logic [WORD_BITS-1:0] w);
      for (int i = fill; i > at; i--) entries[i] = entries[i-1];
      entries[at] = w;
      fill++;
      if (fill > peak_fill) peak_fill = fill;
    endfunction

    function logic [WORD_BITS-1:0] close_gap(int at);
      logic [WORD_BITS-1:0] w;
      w = entries[at];
      for (int i = at; i + 1 < fill; i++) entries[i] = entries[i+1];
      fill--;
      return w;
    endfunction

    // predict the response word for one accepted request word
    function void note_request(kind_t k, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
      rsp_word_t r;
      int        p;
      r.data = '0;
      r.err = ERR_OK;
      p = int'(pos);
      words_in++;
      case (k)
        K_PUSH_BACK, K_PUSH_FRONT: begin
          if (fill >= DEPTH) r.err = ERR_FULL;
          else open_gap((k == K_PUSH_BACK) ? fill : 0, val[WORD_BITS-1:0]);
        end
        K_INSERT_AT: begin
          if (p > fill) r.err = ERR_RANGE;
          else if (fill >= DEPTH) r.err = ERR_FULL;
          else open_gap(p, val[WORD_BITS-1:0]);
        end
        K_POP_FRONT, K_POP_BACK: begin
          if (fill == 0) r.err = ERR_RANGE;
          else r.data = DATA_W'(close_gap((k == K_POP_FRONT) ? 0 : fill - 1));
        end
        K_REMOVE_AT: begin
          if (p >= fill) r.err = ERR_RANGE;
          else r.data = DATA_W'(close_gap(p));
        end
        K_READ_AT: begin
          if (p >= fill) r.err = ERR_RANGE;
          else r.data = DATA_W'(entries[p]);
        end
        K_READ_FIRST, K_READ_LAST: begin
          if (fill == 0) r.err = ERR_RANGE;
          else r.data = DATA_W'(entries[(k == K_READ_FIRST) ? 0 : fill - 1]);
        end
        K_CLEAR: fill = 0;
        default: ;
      endcase
      if (int'(k) < 10) kind_seen[int'(k)]++;
      err_seen[int'(r.err)]++;
      r.count = COUNT_W'(fill);
      pending.push_back(r);
    endfunction

    function void check_response(logic [DATA_W-1:0] d, logic [ERR_W-1:0] e,
                                 logic [COUNT_W-1:0] c);
      rsp_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response word: data %h error %0d count %0d", $time, d, e, c);
        failures++;
        return;
      end
      w = pending.pop_front();
      words_out++;
      if (d !== w.data) begin
        $display("%0t: data_out mismatch: expected %h actual %h", $time, w.data, d);
        failures++;
      end
      if (e !== w.err) begin
        $display("%0t: error mismatch: expected %0d actual %0d", $time, w.err, e);
        failures++;
      end
      if (c !== w.count) begin
        $display("%0t: count mismatch: expected %0d actual %0d", $time, w.count, c);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  idq_req_if req_ch ();
  idq_rsp_if rsp_ch ();

  indexed_deque #(
    .DEPTH(DEPTH),
    .WORD_BITS(WORD_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  deque_scoreboard sb = new();

  int sent_count = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = '0;
    req_ch.position = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("%0t: run timed out with %0d responses outstanding", $time, sb.pending.size());
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(kind_t'(req_ch.kind), req_ch.position, req_ch.value);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.data_out, rsp_ch.error, rsp_ch.count);
    end
  end

  // response side: random stalls, one long hold-off, steady at the end
  initial begin
    repeat (8) @(negedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic send_word(kind_t k, logic [POS_W-1:0] p, logic [VALUE_W-1:0] v);
    req_ch.valid <= 1'b1;
    req_ch.kind <= k;
    req_ch.position <= p;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic idle_req(int n);
    req_ch.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    int                 mode;
    int                 share;
    int                 r;
    int                 fill_now;
    bit                 gappy;
    kind_t              k;
    logic [POS_W-1:0]   p;
    logic [VALUE_W-1:0] v;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list
    send_word(K_POP_FRONT, 0, 32'h0);
    send_word(K_POP_BACK, 0, 32'h0);
    send_word(K_READ_FIRST, 0, 32'h0);
    send_word(K_READ_LAST, 0, 32'h0);
    send_word(K_REMOVE_AT, 0, 32'h0);
    send_word(K_INSERT_AT, 1, 32'h1234_5678);
    // fill to the top
    send_word(K_INSERT_AT, 0, 32'hFFFF_FFFF);
    send_word(K_PUSH_BACK, 0, 32'h0000_0000);
    send_word(K_PUSH_FRONT, 0, 32'h8000_0001);
    for (int i = 0; i < DEPTH - 3; i++)
      send_word(kind_t'($urandom_range(0, 2)), POS_W'($urandom_range(0, 3 + i)), $urandom);
    // full list
    send_word(K_PUSH_BACK, 0, 32'hAAAA_5555);
    send_word(K_INSERT_AT, 16, 32'h5555_AAAA);
    send_word(K_READ_LAST, 0, 32'h0);
    send_word(K_READ_AT, 16, 32'h0);
    send_word(K_REMOVE_AT, 15, 32'h0);
    send_word(K_POP_BACK, 0, 32'h0);
    send_word(K_CLEAR, 0, 32'h0);

    mode = 2;
    gappy = 1'b0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 60 == 0) begin
        mode = $urandom_range(0, 2);
        gappy = ($urandom_range(0, 2) != 0);
      end
      if (i >= RAND_WORDS - CALM_TAIL) calm = 1'b1;
      share = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      r = $urandom_range(0, 99);
      if (r < share) k = kind_t'($urandom_range(0, 2));
      else if ($urandom_range(0, 40) == 0) k = K_CLEAR;
      else k = kind_t'($urandom_range(3, 8));
      fill_now = sb.fill;
      if ($urandom_range(0, 4) != 0) p = POS_W'($urandom_range(0, fill_now));
      else p = POS_W'($urandom_range(0, 16));
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        default: v = $urandom;
      endcase
      send_word(k, p, v);
      if (!calm && gappy && $urandom_range(0, 3) == 0) idle_req($urandom_range(1, 8));
    end
    req_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d request words and %0d response words, peak fill %0d of %0d",
             sb.words_in, sb.words_out, sb.peak_fill, DEPTH);
    $display("results: %0d ok, %0d range or empty, %0d full, %0d clears",
             sb.err_seen[0], sb.err_seen[1], sb.err_seen[2], sb.kind_seen[9]);
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
